### rtl/bma_pkg.sv
// Shared types and constants for the block map allocator.
// No dependencies; imported by block_map_allocator and bma_seq.
`default_nettype none
package bma_pkg;

  localparam int HEAP_BLOCKS_DEF = 256;

  localparam int FUNC_W   = 1;
  localparam int ADDR_W   = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int HSIZE_W  = 9;
  localparam int LEN_W    = 9;

  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_IDX_HEAP_SIZE = 1'b0;
  localparam logic [HSIZE_W-1:0] HEAP_SIZE_RST = 9'd256;

  typedef struct packed {
    logic             alloc;
    logic             head;
    logic [LEN_W-1:0] len;
  } blk_entry_t;

  localparam int ENTRY_W = $bits(blk_entry_t);

endpackage
`default_nettype wire

### rtl/block_map_allocator.sv
// Top level of the block map allocator: configuration register, sequencer and map RAM.
// Depends on bma_pkg, bma_ram and bma_seq.
`default_nettype none
// After reset the block clears every entry of its map RAM with busy high; register
// writes are taken during that time. A request is transferred when start is high and
// busy is low. A range error is reported in the cycle after the request. An allocation
// of n blocks reads the map RAM once per block to check and then writes once per block
// to mark, and a delete reads the head entry and then writes once per block of its run
// to clear it, all in series through the map RAM. Each result appears on out_status
// with out_valid high for one cycle and must be taken in that cycle.
module block_map_allocator
  import bma_pkg::*;
#(
  parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [FUNC_W-1:0]     in_func,
  input  wire logic [ADDR_W-1:0]     in_address,
  input  wire logic [COUNT_W-1:0]    in_count,
  output logic                       out_valid,
  output logic      [STATUS_W-1:0]   out_status,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_AW-1:0]     paddr,
  input  wire logic [CFG_DW-1:0]     pwdata,
  output logic      [CFG_DW-1:0]     prdata,
  output logic                       pready
);

  localparam int AW = $clog2(HEAP_BLOCKS);
  localparam int UW = $clog2(HEAP_BLOCKS + 1);
  localparam int CW = (UW > HSIZE_W) ? UW : HSIZE_W;

  logic [HSIZE_W-1:0] heap_size_r;
  logic [CW-1:0]      usable_w;
  logic [UW-1:0]      usable;
  logic               cfg_wr;

  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_size_r <= HEAP_SIZE_RST;
    end else if (cfg_wr && paddr[2] == CFG_IDX_HEAP_SIZE) begin
      heap_size_r <= pwdata[HSIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == CFG_IDX_HEAP_SIZE) ? CFG_DW'(heap_size_r) : '0;

  assign usable_w = (CW'(heap_size_r) < CW'(HEAP_BLOCKS)) ? CW'(heap_size_r)
                                                          : CW'(HEAP_BLOCKS);
  assign usable   = usable_w[UW-1:0];

  bma_seq #(
    .HEAP_BLOCKS (HEAP_BLOCKS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .func        (in_func),
    .address     (in_address),
    .count       (in_count),
    .usable      (usable),
    .busy        (busy),
    .res_valid   (out_valid),
    .res_status  (out_status),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  bma_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_BLOCKS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_zero_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_ALLOC && in_count == '0
    |=> out_valid && out_status == ST_RANGE)
    else $error("zero-count allocate not reported as range error");

  a_delete_range: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_DELETE && CW'(in_address) >= usable_w
    |=> out_valid && out_status == ST_RANGE)
    else $error("delete outside heap not reported as range error");

  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result without a request");

endmodule
`default_nettype wire

### rtl/bma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module bma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/bma_seq.sv
// Sequencer that walks the block map one entry per cycle through the map RAM.
// Depends on bma_pkg; drives the ports of one bma_ram instance.
`default_nettype none
module bma_seq
  import bma_pkg::*;
#(
  parameter int HEAP_BLOCKS = HEAP_BLOCKS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [FUNC_W-1:0]                    func,
  input  wire logic [ADDR_W-1:0]                    address,
  input  wire logic [COUNT_W-1:0]                   count,
  input  wire logic [$clog2(HEAP_BLOCKS+1)-1:0]     usable,
  output logic                                      busy,
  output logic                                      res_valid,
  output logic      [STATUS_W-1:0]                  res_status,
  output logic                                      ram_wr_en,
  output logic      [$clog2(HEAP_BLOCKS)-1:0]       ram_wr_addr,
  output logic      [ENTRY_W-1:0]                   ram_wr_data,
  output logic                                      ram_rd_en,
  output logic      [$clog2(HEAP_BLOCKS)-1:0]       ram_rd_addr,
  input  wire logic [ENTRY_W-1:0]                   ram_rd_data
);

  localparam int AW = $clog2(HEAP_BLOCKS);
  localparam int UW = $clog2(HEAP_BLOCKS + 1);
  localparam int SW = (UW > ADDR_W + 2) ? UW : ADDR_W + 2;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CHECK = 6'b000100,
    S_MARK  = 6'b001000,
    S_DHEAD = 6'b010000,
    S_DCLR  = 6'b100000
  } bma_state_t;

  bma_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r, base_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                rvalid_r, rvalid_nxt;
  logic                rlast_r, rlast_nxt;
  logic                res_valid_r, res_valid_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  blk_entry_t          rd_entry;
  blk_entry_t          wr_entry;
  logic [COUNT_W-1:0]  idx_inc;
  logic [SW-1:0]       blk_sum;
  logic [SW-1:0]       req_end;

  assign rd_entry    = blk_entry_t'(ram_rd_data);
  assign ram_wr_data = wr_entry;
  assign idx_inc     = idx_r + COUNT_W'(1);
  assign blk_sum     = SW'(base_r) + SW'(idx_r);
  assign req_end     = SW'(address) + SW'(count);

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    clr_nxt        = clr_r;
    rvalid_nxt     = 1'b0;
    rlast_nxt      = rlast_r;
    res_valid_nxt  = 1'b0;
    res_status_nxt = res_status_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = blk_sum[AW-1:0];
    wr_entry       = '0;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = blk_sum[AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_r;
        clr_nxt     = clr_r + AW'(1);
        if (clr_r == AW'(HEAP_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          base_nxt = address;
          cnt_nxt  = count;
          idx_nxt  = '0;
          if (func == FUNC_ALLOC) begin
            if (count == '0 || req_end > SW'(usable)) begin
              res_valid_nxt  = 1'b1;
              res_status_nxt = ST_RANGE;
            end else begin
              state_nxt = S_CHECK;
            end
          end else begin
            if (SW'(address) >= SW'(usable)) begin
              res_valid_nxt  = 1'b1;
              res_status_nxt = ST_RANGE;
            end else begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = req_end[AW-1:0] - AW'(count);
              state_nxt   = S_DHEAD;
            end
          end
        end
      end
      S_CHECK: begin
        if (rvalid_r && rd_entry.alloc) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_CONFLICT;
          state_nxt      = S_IDLE;
        end else if (rvalid_r && rlast_r) begin
          idx_nxt   = '0;
          state_nxt = S_MARK;
        end else if (idx_r != cnt_r) begin
          ram_rd_en  = 1'b1;
          rvalid_nxt = 1'b1;
          rlast_nxt  = (idx_inc == cnt_r);
          idx_nxt    = idx_inc;
        end
      end
      S_MARK: begin
        ram_wr_en      = 1'b1;
        wr_entry.alloc = 1'b1;
        wr_entry.head  = (idx_r == '0);
        wr_entry.len   = (idx_r == '0) ? LEN_W'(cnt_r) : '0;
        idx_nxt        = idx_inc;
        if (idx_inc == cnt_r) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_DHEAD: begin
        if (!rd_entry.head) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_CONFLICT;
          state_nxt      = S_IDLE;
        end else if (rd_entry.len == '0) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else begin
          cnt_nxt   = COUNT_W'(rd_entry.len);
          idx_nxt   = '0;
          state_nxt = S_DCLR;
        end
      end
      S_DCLR: begin
        ram_wr_en = (blk_sum < SW'(HEAP_BLOCKS));
        idx_nxt   = idx_inc;
        if (idx_inc == cnt_r || blk_sum + SW'(1) >= SW'(HEAP_BLOCKS)) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rvalid_r    <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rvalid_r    <= rvalid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    cnt_r        <= cnt_nxt;
    idx_r        <= idx_nxt;
    rlast_r      <= rlast_nxt;
    res_status_r <= res_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign res_valid  = res_valid_r;
  assign res_status = res_status_r;

endmodule
`default_nettype wire
